FILE: hdl/mdr_pkg.sv
package mdr_pkg;

  localparam int DataW = 32;
  localparam int QuoW  = DataW - 1;
  localparam int NumW  = 2 * DataW - 1;

  typedef struct packed {
    logic signed [DataW-1:0] multiplicand;
    logic signed [DataW-1:0] multiplier;
    logic signed [DataW-1:0] divisor;
  } op_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] quotient;
    logic                    error;
  } res_word_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic err;
  } ctl_t;

  localparam logic [DataW-1:0] ErrWord = {DataW{1'b1}};

endpackage

FILE: hdl/mdr_prep.sv
module mdr_prep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        op_valid,
  input  mdr_pkg::op_word_t           op,
  output mdr_pkg::ctl_t               ctl,
  output logic [mdr_pkg::DataW-1:0]   amag,
  output logic [mdr_pkg::DataW-1:0]   bmag,
  output logic [mdr_pkg::DataW-1:0]   dmag
);

  logic [mdr_pkg::DataW-1:0] a_raw;
  logic [mdr_pkg::DataW-1:0] b_raw;
  logic [mdr_pkg::DataW-1:0] d_raw;
  logic                      a_neg;
  logic                      b_neg;
  logic                      d_neg;
  logic                      a_eff_neg;
  mdr_pkg::ctl_t             ctl_next;
  logic [mdr_pkg::DataW-1:0] amag_next;
  logic [mdr_pkg::DataW-1:0] bmag_next;
  logic [mdr_pkg::DataW-1:0] dmag_next;

  always_comb begin
    a_raw = op.multiplicand;
    b_raw = op.multiplier;
    d_raw = op.divisor;
    a_neg = a_raw[mdr_pkg::DataW-1];
    b_neg = b_raw[mdr_pkg::DataW-1];
    d_neg = d_raw[mdr_pkg::DataW-1];
    // negative divisor flips the multiplicand; zero stays non-negative
    a_eff_neg = (a_raw != '0) && (a_neg ^ d_neg);
    amag_next = a_neg ? -a_raw : a_raw;
    bmag_next = b_neg ? -b_raw : b_raw;
    dmag_next = d_neg ? -d_raw : d_raw;
    ctl_next.valid = op_valid;
    ctl_next.neg   = a_eff_neg ^ b_neg;
    ctl_next.err   = (d_raw == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amag <= amag_next;
      bmag <= bmag_next;
      dmag <= dmag_next;
    end
  end

endmodule

FILE: hdl/mdr_mul.sv
module mdr_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  mdr_pkg::ctl_t               ctl_in,
  input  logic [mdr_pkg::DataW-1:0]   amag,
  input  logic [mdr_pkg::DataW-1:0]   bmag,
  input  logic [mdr_pkg::DataW-1:0]   dmag_in,
  output mdr_pkg::ctl_t               ctl,
  output logic [mdr_pkg::NumW-1:0]    acc,
  output logic [mdr_pkg::DataW-1:0]   dmag
);

  logic [2*mdr_pkg::DataW-1:0] prod_full;
  mdr_pkg::ctl_t               ctl_p;
  logic [mdr_pkg::NumW-1:0]    prod;
  logic [mdr_pkg::DataW-1:0]   dmag_p;
  logic [mdr_pkg::NumW-1:0]    num;
  logic                        ovf;
  mdr_pkg::ctl_t               ctl_next;

  assign prod_full = amag * bmag;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p.valid <= 1'b0;
    end else if (en) begin
      ctl_p <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= prod_full[mdr_pkg::NumW-1:0];
      dmag_p <= dmag_in;
    end
  end

  // rounding offset and range check
  always_comb begin
    num = prod + mdr_pkg::NumW'(dmag_p >> 1);
    ovf = num[mdr_pkg::NumW-1:mdr_pkg::QuoW] >= dmag_p;
    ctl_next     = ctl_p;
    ctl_next.err = ctl_p.err | ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc  <= num;
      dmag <= dmag_p;
    end
  end

endmodule

FILE: hdl/mdr_div_step.sv
module mdr_div_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  mdr_pkg::ctl_t               ctl_in,
  input  logic [mdr_pkg::NumW-1:0]    acc_in,
  input  logic [mdr_pkg::DataW-1:0]   dmag_in,
  output mdr_pkg::ctl_t               ctl,
  output logic [mdr_pkg::NumW-1:0]    acc,
  output logic [mdr_pkg::DataW-1:0]   dmag
);

  logic [mdr_pkg::NumW:0]    sh;
  logic [mdr_pkg::DataW:0]   top;
  logic [mdr_pkg::DataW:0]   diff;
  logic                      qbit;
  logic [mdr_pkg::NumW-1:0]  acc_next;

  // one restoring step: remainder in the upper bits, quotient fills from the bottom
  always_comb begin
    sh       = {acc_in, 1'b0};
    top      = sh[mdr_pkg::NumW:mdr_pkg::QuoW];
    diff     = top - {1'b0, dmag_in};
    qbit     = top >= {1'b0, dmag_in};
    acc_next = {(qbit ? diff[mdr_pkg::DataW-1:0] : top[mdr_pkg::DataW-1:0]),
                sh[mdr_pkg::QuoW-1:1], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc  <= acc_next;
      dmag <= dmag_in;
    end
  end

endmodule

FILE: hdl/mul_div_rounded_core.sv
// mul_div_rounded_core: rounded (multiplicand * multiplier) / divisor
//
// operand channel op_valid / op_ready / op carries one word of three signed
// 32-bit operands; result channel res_valid / res_ready / res carries the
// signed quotient and an error flag. a zero divisor or a quotient outside
// +/-2147483647 returns all ones with error set.
//
// from an accepted operand word to res_valid the word passes through one
// stage of magnitudes, one of 32x32 multiply, one of rounding add and range
// compare, 31 restoring divide stages at one quotient bit each, and the
// output register. a new word is taken every cycle while op_ready is high.
//
// every stage advances together whenever the output register is empty or
// being taken. while the receiver holds res_ready low with a word waiting,
// op_ready is low and the whole pipeline holds; nothing is dropped or
// repeated.
//
// rst (synchronous) clears all valid bits; the pipeline is empty afterwards.
module mul_div_rounded_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  output logic                op_ready,
  input  mdr_pkg::op_word_t   op,
  output logic                res_valid,
  input  logic                res_ready,
  output mdr_pkg::res_word_t  res
);

  logic                      en;
  mdr_pkg::ctl_t             ctl_prep;
  logic [mdr_pkg::DataW-1:0] amag;
  logic [mdr_pkg::DataW-1:0] bmag;
  logic [mdr_pkg::DataW-1:0] dmag_prep;

  mdr_pkg::ctl_t             ctl_s  [mdr_pkg::QuoW+1];
  logic [mdr_pkg::NumW-1:0]  acc_s  [mdr_pkg::QuoW+1];
  logic [mdr_pkg::DataW-1:0] dmag_s [mdr_pkg::QuoW+1];

  logic [mdr_pkg::DataW-1:0] qmag;
  mdr_pkg::ctl_t             ctl_last;
  mdr_pkg::res_word_t        res_next;

  assign en       = !res_valid || res_ready;
  assign op_ready = en;

  mdr_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .op_valid (op_valid),
    .op       (op),
    .ctl      (ctl_prep),
    .amag     (amag),
    .bmag     (bmag),
    .dmag     (dmag_prep)
  );

  mdr_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_prep),
    .amag    (amag),
    .bmag    (bmag),
    .dmag_in (dmag_prep),
    .ctl     (ctl_s[0]),
    .acc     (acc_s[0]),
    .dmag    (dmag_s[0])
  );

  for (genvar i = 0; i < mdr_pkg::QuoW; i++) begin : g_div
    mdr_div_step u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_s[i]),
      .acc_in  (acc_s[i]),
      .dmag_in (dmag_s[i]),
      .ctl     (ctl_s[i+1]),
      .acc     (acc_s[i+1]),
      .dmag    (dmag_s[i+1])
    );
  end

  always_comb begin
    ctl_last = ctl_s[mdr_pkg::QuoW];
    qmag     = {1'b0, acc_s[mdr_pkg::QuoW][mdr_pkg::QuoW-1:0]};
    if (ctl_last.err) begin
      res_next.quotient = mdr_pkg::ErrWord;
      res_next.error    = 1'b1;
    end else begin
      res_next.quotient = ctl_last.neg ? -qmag : qmag;
      res_next.error    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= ctl_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  a_err_word : assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error |-> res.quotient == mdr_pkg::ErrWord)
    else $error("error word without all-ones quotient");

  a_range : assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.error |-> res.quotient != {1'b1, {(mdr_pkg::DataW-1){1'b0}}})
    else $error("quotient outside range without error");

  a_stall_only_downstream : assert property (@(posedge clk) disable iff (rst)
    !op_ready |-> res_valid && !res_ready)
    else $error("operand side stalled without a blocked result");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid straight after reset");

  a_zero_divisor : assert property (@(posedge clk) disable iff (rst)
    ctl_prep.valid && dmag_prep == '0 |-> ctl_prep.err)
    else $error("zero divisor not flagged");

endmodule

FILE: tb/sv/tb_mul_div_rounded_core.sv
`timescale 1ns / 1ps

module tb_mul_div_rounded_core;

  localparam logic signed [mdr_pkg::DataW-1:0] MaxPos = 32'sh7fff_ffff;
  localparam logic signed [mdr_pkg::DataW-1:0] MaxNeg = 32'sh8000_0000;
  localparam longint QuoMax = 64'sd2147483647;
  localparam longint QuoMin = -64'sd2147483647;
  localparam int DrainCycles = 60;

  logic clk;
  logic rst = 1'b1;
  logic op_valid = 1'b0;
  logic op_ready;
  mdr_pkg::op_word_t op = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  mdr_pkg::res_word_t res;

  mdr_pkg::op_word_t op_backlog[$];
  mdr_pkg::res_word_t quotients_due[$];
  logic op_taken;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;

  mul_div_rounded_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("mul_div_rounded_core test failed");
    $finish;
  end

  function automatic mdr_pkg::res_word_t rounded_quotient(mdr_pkg::op_word_t w);
    longint num_a;
    longint num_b;
    longint den;
    longint prod;
    longint half;
    longint q;
    mdr_pkg::res_word_t r;
    num_a = longint'($signed(w.multiplicand));
    num_b = longint'($signed(w.multiplier));
    den = longint'($signed(w.divisor));
    r.quotient = mdr_pkg::ErrWord;
    r.error = 1'b1;
    if (den != 0) begin
      if (den < 0) begin
        num_a = -num_a;
        den = -den;
      end
      prod = num_a * num_b;
      half = den / 2;
      if ((num_a < 0 && num_b < 0) || (num_a >= 0 && num_b >= 0)) begin
        q = (prod + half) / den;
      end else begin
        q = (prod - half) / den;
      end
      if (q <= QuoMax && q >= QuoMin) begin
        r.quotient = q[mdr_pkg::DataW-1:0];
        r.error = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic push_op(input logic signed [mdr_pkg::DataW-1:0] a,
                         input logic signed [mdr_pkg::DataW-1:0] b,
                         input logic signed [mdr_pkg::DataW-1:0] d);
    mdr_pkg::op_word_t w;
    w.multiplicand = a;
    w.multiplier = b;
    w.divisor = d;
    op_backlog.push_back(w);
  endtask

  function automatic logic signed [mdr_pkg::DataW-1:0] edge_value();
    case ($urandom_range(6))
      0: return 0;
      1: return 1;
      2: return -1;
      3: return MaxPos;
      4: return MaxNeg;
      5: return 2;
      default: return -2;
    endcase
  endfunction

  function automatic logic signed [mdr_pkg::DataW-1:0] small_value();
    logic signed [mdr_pkg::DataW-1:0] v;
    v = $urandom_range(2000);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic mdr_pkg::op_word_t random_op();
    mdr_pkg::op_word_t w;
    longint span;
    longint k;
    longint num;
    int pick;
    pick = $urandom_range(99);
    w.multiplicand = $urandom();
    w.multiplier = $urandom();
    w.divisor = $urandom();
    if (pick < 30) begin
      w.multiplicand = small_value();
      w.multiplier = small_value();
      w.divisor = small_value();
    end else if (pick < 60) begin
      // short multiplier against a wide divisor keeps most quotients in range
      w.multiplier = $signed($urandom()) >>> $urandom_range(16, 31);
    end else if (pick < 75) begin
      // exact ties: product sits halfway between two multiples
      span = 2 * $urandom_range(1, 5000);
      k = $urandom_range(100000);
      num = k * span + span / 2;
      w.multiplicand = $urandom_range(1) ? -num[mdr_pkg::DataW-1:0] : num[mdr_pkg::DataW-1:0];
      w.multiplier = $urandom_range(1) ? -1 : 1;
      w.divisor = $urandom_range(1) ? -span[mdr_pkg::DataW-1:0] : span[mdr_pkg::DataW-1:0];
    end else if (pick < 85) begin
      w.multiplicand = edge_value();
      w.multiplier = edge_value();
      w.divisor = edge_value();
    end else if (pick < 90) begin
      w.divisor = 0;
    end
    return w;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!op_valid || op_taken) begin
        if (op_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          op <= op_backlog.pop_front();
          op_valid <= 1'b1;
        end else begin
          op_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    mdr_pkg::res_word_t want;
    if (rst) begin
      op_taken <= 1'b0;
    end else begin
      op_taken <= op_valid && op_ready;
      if (op_valid && op_ready) begin
        quotients_due.push_back(rounded_quotient(op));
      end
      if (res_valid && res_ready) begin
        if (quotients_due.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending: %h", res));
        end else begin
          want = quotients_due.pop_front();
          if (res.quotient !== want.quotient) begin
            report_mismatch($sformatf("quotient %h, want %h", res.quotient, want.quotient));
          end
          if (res.error !== want.error) begin
            report_mismatch($sformatf("error %b, want %b", res.error, want.error));
          end
        end
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    push_op(MaxNeg, MaxNeg, MaxNeg);
    push_op(MaxNeg, 1, -1);
    push_op(MaxNeg, 1, MaxNeg);
    push_op(MaxNeg, 1, 1);
    push_op(-MaxPos, 1, 1);
    push_op(MaxPos, MaxPos, MaxPos);
    push_op(MaxPos, MaxPos, 1);
    push_op(MaxPos, MaxNeg, MaxNeg);
    push_op(1, 1, 0);
    push_op(0, 0, 0);
    push_op(-1, 1, 1);
    push_op(0, -5, 3);
    push_op(-5, 0, -3);
    push_op(5, 1, 2);
    push_op(-5, 1, 2);
    push_op(7, 1, -2);
    push_op(-7, -1, -2);
    push_op(3, 1, MaxPos);
    push_op(1, 1, MaxNeg);
    push_op(-1, -1, MaxNeg);
    push_op(MaxNeg, -1, 1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 63; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      repeat (158) op_backlog.push_back(random_op());
      // hold off until every pending word has come back
      while (op_backlog.size() != 0 || op_valid || quotients_due.size() != 0)
        @(posedge clk);
    end

    repeat (DrainCycles) @(posedge clk);
    if (quotients_due.size() != 0) begin
      report_mismatch($sformatf("%0d result words never came", quotients_due.size()));
    end
    if (error_count == 0) begin
      $display("mul_div_rounded_core test passed");
    end else begin
      $display("mul_div_rounded_core test failed");
    end
    $finish;
  end

endmodule
